>>> sv/tone_sequence_player_core_macros.svh
// Assertion macros used by the tone sequence player core.
// Depends on nothing; included by the file that carries assertions.
`ifndef TONE_SEQUENCE_PLAYER_CORE_MACROS_SVH
`define TONE_SEQUENCE_PLAYER_CORE_MACROS_SVH

// Plain property, checked on every rising edge outside reset.
`define TSP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication.
`define TSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	`TSP_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

// Next-cycle implication.
`define TSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	`TSP_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

>>> sv/tsp_pkg.sv
// Shared types, constants and helper functions of the tone sequence player.
// Depends on nothing; used by every other RTL file of the block but the macro header.
package tsp_pkg;

	// Store geometry.
	localparam int MAX_EFFECTS      = 16;
	localparam int NOTES_PER_EFFECT = 16;
	localparam int SLOTS            = MAX_EFFECTS * NOTES_PER_EFFECT;

	localparam int EFF_W  = (MAX_EFFECTS > 1) ? $clog2(MAX_EFFECTS) : 1;
	localparam int NOTE_W = (NOTES_PER_EFFECT > 1) ? $clog2(NOTES_PER_EFFECT) : 1;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int POS_W  = $clog2(NOTES_PER_EFFECT + 1);

	// Field widths.
	localparam int OP_W   = 2;
	localparam int TIME_W = 32;
	localparam int SEL_W  = 4;
	localparam int FREQ_W = 16;
	localparam int DUR_W  = 16;
	localparam int LEN_W  = 5;
	localparam int REP_W  = 8;
	localparam int CNT_W  = 5;
	localparam int CMP_W  = (POS_W > LEN_W) ? POS_W : LEN_W;

	// Register port.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_IDX_SOUND_COUNT = 1'b0;

	typedef enum logic [OP_W-1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2,
		OP_LOAD  = 2'd3
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [TIME_W-1:0] time_now;
		logic [SEL_W-1:0]  ssel;
		logic [SEL_W-1:0]  nsel;
		logic [FREQ_W-1:0] freq;
		logic [DUR_W-1:0]  dur;
		logic [LEN_W-1:0]  len;
		logic [REP_W-1:0]  reps;
	} item_t;

	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic [DUR_W-1:0]  dur;
	} note_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [REP_W-1:0] reps;
	} eff_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot_a;
		logic [SLOT_W-1:0] slot_b;
		logic [EFF_W-1:0]  eff;
	} rd_req_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] slot;
		note_t             note;
		logic [EFF_W-1:0]  eff_idx;
		eff_t              eff;
	} wr_req_t;

	typedef struct packed {
		logic              tone_on;
		logic [FREQ_W-1:0] tone_freq;
		logic              playing;
		logic              finished;
	} status_t;

	// Effect index of a select field.
	function automatic logic [EFF_W-1:0] eff_of(input logic [SEL_W-1:0] sel);
		logic [SEL_W+EFF_W-1:0] ext;
		ext = {{EFF_W{1'b0}}, sel};
		return ext[EFF_W-1:0];
	endfunction

	// Note index of a select field.
	function automatic logic [NOTE_W-1:0] note_of(input logic [SEL_W-1:0] sel);
		logic [SEL_W+NOTE_W-1:0] ext;
		ext = {{NOTE_W{1'b0}}, sel};
		return ext[NOTE_W-1:0];
	endfunction

	// Note index of a play position; a position past the store maps to note 0.
	function automatic logic [NOTE_W-1:0] note_of_pos(input logic [POS_W-1:0] pos);
		logic [POS_W+NOTE_W-1:0] ext;
		ext = {{NOTE_W{1'b0}}, pos};
		return (pos >= POS_W'(NOTES_PER_EFFECT)) ? '0 : ext[NOTE_W-1:0];
	endfunction

	// Flat note store address of an effect and a note.
	function automatic logic [SLOT_W-1:0] slot_of(input logic [EFF_W-1:0] eff,
			input logic [NOTE_W-1:0] note);
		return SLOT_W'(eff) * SLOT_W'(NOTES_PER_EFFECT) + SLOT_W'(note);
	endfunction

	function automatic logic eff_in_range(input logic [SEL_W-1:0] sel);
		return 32'(sel) < 32'(MAX_EFFECTS);
	endfunction

	function automatic logic note_in_range(input logic [SEL_W-1:0] sel);
		return 32'(sel) < 32'(NOTES_PER_EFFECT);
	endfunction

endpackage

>>> sv/tsp_note_store.sv
// Note store: frequency and duration of every note slot, two read ports.
// Depends on tsp_pkg; a write and a read of the same slot at one edge are forwarded.
module tsp_note_store (
	input  logic             clk,
	input  logic             rd_en,
	input  tsp_pkg::rd_req_t rd_req,
	input  tsp_pkg::wr_req_t wr_req,
	output tsp_pkg::note_t   note_a,
	output tsp_pkg::note_t   note_b
);

	tsp_pkg::note_t mem_q [tsp_pkg::SLOTS];
	tsp_pkg::note_t rd_a_q;
	tsp_pkg::note_t rd_b_q;
	tsp_pkg::note_t fwd_q;
	logic           hit_a_q;
	logic           hit_b_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_req.en) begin
			mem_q[wr_req.slot] <= wr_req.note;
		end
	end

	// Registered reads, with a note of any write landing on the same slot.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_a_q  <= mem_q[rd_req.slot_a];
			rd_b_q  <= mem_q[rd_req.slot_b];
			hit_a_q <= wr_req.en && (wr_req.slot == rd_req.slot_a);
			hit_b_q <= wr_req.en && (wr_req.slot == rd_req.slot_b);
			fwd_q   <= wr_req.note;
		end
	end

	assign note_a = hit_a_q ? fwd_q : rd_a_q;
	assign note_b = hit_b_q ? fwd_q : rd_b_q;

endmodule

>>> sv/tsp_effect_store.sv
// Effect store: note count and repeat count of every effect, one read port.
// Depends on tsp_pkg; a write and a read of the same effect at one edge are forwarded.
module tsp_effect_store (
	input  logic             clk,
	input  logic             rd_en,
	input  tsp_pkg::rd_req_t rd_req,
	input  tsp_pkg::wr_req_t wr_req,
	output tsp_pkg::eff_t    eff_rd
);

	tsp_pkg::eff_t mem_q [tsp_pkg::MAX_EFFECTS];
	tsp_pkg::eff_t rd_q;
	tsp_pkg::eff_t fwd_q;
	logic          hit_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_req.en) begin
			mem_q[wr_req.eff_idx] <= wr_req.eff;
		end
	end

	// Registered read with same-edge forwarding.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q  <= mem_q[rd_req.eff];
			hit_q <= wr_req.en && (wr_req.eff_idx == rd_req.eff);
			fwd_q <= wr_req.eff;
		end
	end

	assign eff_rd = hit_q ? fwd_q : rd_q;

endmodule

>>> sv/tsp_player.sv
// Player state and its update: note position, repeats, time mark and tone.
// Depends on tsp_pkg; fed by tsp_note_store and tsp_effect_store read data.
module tsp_player (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       fire,
	input  tsp_pkg::item_t             item_s1,
	input  logic [tsp_pkg::SEL_W-1:0]  next_sel,
	input  tsp_pkg::note_t             note_a,
	input  tsp_pkg::note_t             note_b,
	input  tsp_pkg::eff_t              eff_rd,
	input  logic [tsp_pkg::CNT_W-1:0]  sound_count,
	output tsp_pkg::rd_req_t           rd_req,
	output tsp_pkg::wr_req_t           wr_req,
	output tsp_pkg::status_t           status
);

	logic [tsp_pkg::EFF_W-1:0]  active_q, active_n;
	logic [tsp_pkg::POS_W-1:0]  pos_q, pos_n;
	logic [tsp_pkg::REP_W-1:0]  rep_q, rep_n;
	logic [tsp_pkg::TIME_W-1:0] start_q, start_n;
	logic                       playing_q, playing_n;
	logic                       finished_q, finished_n;
	logic                       tone_q, tone_n;
	logic [tsp_pkg::FREQ_W-1:0] freq_q, freq_n;
	logic [tsp_pkg::FREQ_W-1:0] first_q, first_n;

	logic [tsp_pkg::TIME_W-1:0] elapsed;
	logic [tsp_pkg::POS_W-1:0]  pos_inc;
	logic [tsp_pkg::POS_W-1:0]  pos_n_inc;
	logic [tsp_pkg::REP_W-1:0]  rep_inc;
	logic                       due;
	logic                       wrap;
	logic                       last_rep;
	logic                       start_ok;
	logic                       load_ok;
	logic [tsp_pkg::FREQ_W-1:0] f_next;

	// Advance decision for the item in hand.
	assign elapsed  = item_s1.time_now - start_q;
	assign due      = elapsed >= tsp_pkg::TIME_W'(note_a.dur);
	assign pos_inc  = pos_q + tsp_pkg::POS_W'(1);
	assign rep_inc  = rep_q + tsp_pkg::REP_W'(1);
	assign wrap     = (tsp_pkg::CMP_W'(pos_inc) >= tsp_pkg::CMP_W'(eff_rd.len)) ||
		(pos_inc >= tsp_pkg::POS_W'(tsp_pkg::NOTES_PER_EFFECT));
	assign last_rep = rep_inc >= eff_rd.reps;
	assign f_next   = wrap ? first_q : note_b.freq;
	assign start_ok = tsp_pkg::eff_in_range(item_s1.ssel) &&
		(tsp_pkg::CNT_W'(item_s1.ssel) < sound_count);
	assign load_ok  = tsp_pkg::eff_in_range(item_s1.ssel) &&
		tsp_pkg::note_in_range(item_s1.nsel);

	// Next state; equal to the present state unless an item completes.
	always_comb begin
		active_n   = active_q;
		pos_n      = pos_q;
		rep_n      = rep_q;
		start_n    = start_q;
		playing_n  = playing_q;
		finished_n = finished_q;
		tone_n     = tone_q;
		freq_n     = freq_q;
		first_n    = first_q;
		if (fire) begin
			case (item_s1.op)
				tsp_pkg::OP_TICK, tsp_pkg::OP_START: begin
					if (playing_q) begin
						if (due) begin
							if (wrap) begin
								rep_n = rep_inc;
								if (last_rep) begin
									playing_n  = 1'b0;
									finished_n = 1'b1;
									tone_n     = 1'b0;
									freq_n     = '0;
									pos_n      = pos_inc;
								end else begin
									pos_n   = '0;
									tone_n  = (f_next != '0);
									freq_n  = f_next;
									start_n = item_s1.time_now;
								end
							end else begin
								pos_n   = pos_inc;
								tone_n  = (f_next != '0);
								freq_n  = f_next;
								start_n = item_s1.time_now;
							end
						end
					end else if ((item_s1.op == tsp_pkg::OP_START) && start_ok) begin
						active_n   = tsp_pkg::eff_of(item_s1.ssel);
						pos_n      = '0;
						rep_n      = '0;
						start_n    = item_s1.time_now;
						playing_n  = 1'b1;
						finished_n = 1'b0;
						tone_n     = (note_b.freq != '0);
						freq_n     = note_b.freq;
						first_n    = note_b.freq;
					end
				end
				tsp_pkg::OP_STOP: begin
					tone_n     = 1'b0;
					freq_n     = '0;
					playing_n  = 1'b0;
					finished_n = 1'b1;
				end
				tsp_pkg::OP_LOAD: begin
					// Keep the copy of the active effect's first note current.
					if (load_ok && (tsp_pkg::eff_of(item_s1.ssel) == active_q) &&
							(item_s1.nsel == '0)) begin
						first_n = item_s1.freq;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= '0;
			pos_q      <= '0;
			rep_q      <= '0;
			start_q    <= '0;
			playing_q  <= 1'b0;
			finished_q <= 1'b1;
			tone_q     <= 1'b0;
			freq_q     <= '0;
			first_q    <= '0;
		end else begin
			active_q   <= active_n;
			pos_q      <= pos_n;
			rep_q      <= rep_n;
			start_q    <= start_n;
			playing_q  <= playing_n;
			finished_q <= finished_n;
			tone_q     <= tone_n;
			freq_q     <= freq_n;
			first_q    <= first_n;
		end
	end

	// Reads for the incoming beat follow the state this edge leaves behind.
	assign pos_n_inc     = pos_n + tsp_pkg::POS_W'(1);
	assign rd_req.slot_a = tsp_pkg::slot_of(active_n, tsp_pkg::note_of_pos(pos_n));
	assign rd_req.slot_b = playing_n ?
		tsp_pkg::slot_of(active_n, tsp_pkg::note_of_pos(pos_n_inc)) :
		tsp_pkg::slot_of(tsp_pkg::eff_of(next_sel), '0);
	assign rd_req.eff    = active_n;

	// Table writes from a load.
	assign wr_req.en        = fire && (item_s1.op == tsp_pkg::OP_LOAD) && load_ok;
	assign wr_req.slot      = tsp_pkg::slot_of(tsp_pkg::eff_of(item_s1.ssel),
		tsp_pkg::note_of(item_s1.nsel));
	assign wr_req.note.freq = item_s1.freq;
	assign wr_req.note.dur  = item_s1.dur;
	assign wr_req.eff_idx   = tsp_pkg::eff_of(item_s1.ssel);
	assign wr_req.eff.len   = item_s1.len;
	assign wr_req.eff.reps  = item_s1.reps;

	assign status.tone_on   = tone_q;
	assign status.tone_freq = freq_q;
	assign status.playing   = playing_q;
	assign status.finished  = finished_q;

endmodule

>>> sv/tone_sequence_player_core.sv
// Tone sequence player: accepts one beat per cycle and returns one result beat for each.
// Each beat reads the note store at two slots and the effect store at one entry in the
// cycle it is accepted; the player then updates its state from that data once the result
// slot is free. The sustained rate is one beat per clock, and the input stalls only while
// a finished result waits on a stalled output. Loads forward to reads of the same slot, so
// back-to-back loads and ticks see the newest table contents. The stores have no reset; a
// note or effect read before it was ever loaded gives arbitrary values. The user must write
// sound_count via the register port while the block is idle; the block does not enforce it.
// Depends on tsp_pkg, tsp_note_store, tsp_effect_store, tsp_player and the macro header.
`include "tone_sequence_player_core_macros.svh"

module tone_sequence_player_core (
	input  logic                         clk,
	input  logic                         arst_n,
	// Register port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tsp_pkg::PADDR_W-1:0]  paddr,
	input  logic [tsp_pkg::PDATA_W-1:0]  pwdata,
	output logic [tsp_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	// Input channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [tsp_pkg::OP_W-1:0]     operation,
	input  logic [tsp_pkg::TIME_W-1:0]   time_now,
	input  logic [tsp_pkg::SEL_W-1:0]    sound_sel,
	input  logic [tsp_pkg::SEL_W-1:0]    note_sel,
	input  logic [tsp_pkg::FREQ_W-1:0]   note_freq,
	input  logic [tsp_pkg::DUR_W-1:0]    note_duration,
	input  logic [tsp_pkg::LEN_W-1:0]    sound_length,
	input  logic [tsp_pkg::REP_W-1:0]    sound_repeats,
	// Output channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         tone_on,
	output logic [tsp_pkg::FREQ_W-1:0]   tone_freq,
	output logic                         is_playing,
	output logic                         is_finished
);

	logic [tsp_pkg::CNT_W-1:0] sound_count_q;
	tsp_pkg::item_t            item_in;
	tsp_pkg::item_t            item_s1;
	logic                      v_s1;
	logic                      out_valid_q;
	logic                      fire_s1;
	logic                      accept;
	logic                      cfg_wr;
	tsp_pkg::rd_req_t          rd_req;
	tsp_pkg::wr_req_t          wr_req;
	tsp_pkg::note_t            note_a;
	tsp_pkg::note_t            note_b;
	tsp_pkg::eff_t             eff_rd;
	tsp_pkg::status_t          status;

	// Register port: one register; its low CNT_W bits read back as written.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready &&
		(paddr[tsp_pkg::PADDR_W-1] == tsp_pkg::REG_IDX_SOUND_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sound_count_q <= '0;
		end else if (cfg_wr) begin
			sound_count_q <= pwdata[tsp_pkg::CNT_W-1:0];
		end
	end

	assign prdata = (paddr[tsp_pkg::PADDR_W-1] == tsp_pkg::REG_IDX_SOUND_COUNT) ?
		tsp_pkg::PDATA_W'(sound_count_q) : '0;

	// Handshake: the stage completes when the result slot is free or being taken.
	assign fire_s1  = v_s1 && (!out_valid_q || !out_stall);
	assign in_stall = v_s1 && !fire_s1;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		item_in.op       = tsp_pkg::op_t'(operation);
		item_in.time_now = time_now;
		item_in.ssel     = sound_sel;
		item_in.nsel     = note_sel;
		item_in.freq     = note_freq;
		item_in.dur      = note_duration;
		item_in.len      = sound_length;
		item_in.reps     = sound_repeats;
	end

	// Beat held, like its store read data, until the player takes it.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= accept || (v_s1 && !fire_s1);
			if (fire_s1) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	tsp_note_store u_note_store (
		.clk    (clk),
		.rd_en  (accept),
		.rd_req (rd_req),
		.wr_req (wr_req),
		.note_a (note_a),
		.note_b (note_b)
	);

	tsp_effect_store u_effect_store (
		.clk    (clk),
		.rd_en  (accept),
		.rd_req (rd_req),
		.wr_req (wr_req),
		.eff_rd (eff_rd)
	);

	tsp_player u_player (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire_s1),
		.item_s1     (item_s1),
		.next_sel    (sound_sel),
		.note_a      (note_a),
		.note_b      (note_b),
		.eff_rd      (eff_rd),
		.sound_count (sound_count_q),
		.rd_req      (rd_req),
		.wr_req      (wr_req),
		.status      (status)
	);

	// The player state itself is the result register.
	assign out_valid   = out_valid_q;
	assign tone_on     = status.tone_on;
	assign tone_freq   = status.tone_freq;
	assign is_playing  = status.playing;
	assign is_finished = status.finished;

	// Checks on the player state and the stage control.
	`TSP_ASSERT(a_play_fin_excl, clk, arst_n, !(is_playing && is_finished), "playing and finished both set")
	`TSP_ASSERT_IMP(a_tone_needs_play, clk, arst_n, tone_on, is_playing, "tone sounds while not playing")
	`TSP_ASSERT(a_freq_zero_off, clk, arst_n, ((tone_freq != '0) == tone_on), "tone frequency and tone flag disagree")
	`TSP_ASSERT_IMP(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall, "input stalled with result slot free")
	`TSP_ASSERT_NEXT(a_s1_kept, clk, arst_n, v_s1 && !fire_s1, v_s1, "held beat dropped from stage")

endmodule

>>> tb/tone_sequence_player_core_tb.sv
// Self-checking testbench for tone_sequence_player_core: directed and random beats,
// a running prediction of the player, and a field-by-field check of every result beat.
// Depends on tsp_pkg and the tone_sequence_player_core RTL.
module tone_sequence_player_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tsp_pkg::*;

	localparam int RUN_LIMIT       = 300000;
	localparam int BEATS_PER_PHASE = 280;
	localparam int HOLD_CYCLES     = 400;
	localparam int HOLD_AFTER      = 500;
	localparam logic [PADDR_W-1:0] SOUND_COUNT_ADDR = PADDR_W'(4 * REG_IDX_SOUND_COUNT);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic out_valid;
	logic out_stall = 1'b0;
	logic tone_on;
	logic [FREQ_W-1:0] tone_freq;
	logic is_playing;
	logic is_finished;
	item_t cur_beat = '0;

	tone_sequence_player_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(cur_beat.op),
		.time_now(cur_beat.time_now),
		.sound_sel(cur_beat.ssel),
		.note_sel(cur_beat.nsel),
		.note_freq(cur_beat.freq),
		.note_duration(cur_beat.dur),
		.sound_length(cur_beat.len),
		.sound_repeats(cur_beat.reps),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.tone_on(tone_on),
		.tone_freq(tone_freq),
		.is_playing(is_playing),
		.is_finished(is_finished)
	);

	// Beats waiting to be offered, and player states still to come back.
	item_t beat_q[$];
	status_t status_q[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int fail_n = 0;
	int checked_n = 0;
	int cycle_n = 0;
	int hold_left = 0;
	bit held = 1'b0;
	int phase_counts[6] = '{16, 0, 7, 16, 1, 12};

	// Coverage tallies for the closing summary.
	int ticks_n = 0;
	int starts_n = 0;
	int refused_n = 0;
	int stops_n = 0;
	int loads_n = 0;
	int note_steps_n = 0;
	int played_out_n = 0;

	// Predicted player: tables, sound_count copy and play state.
	logic [FREQ_W-1:0] freq_mem [MAX_EFFECTS][NOTES_PER_EFFECT];
	logic [DUR_W-1:0]  dur_mem  [MAX_EFFECTS][NOTES_PER_EFFECT];
	logic [LEN_W-1:0]  len_mem  [MAX_EFFECTS];
	logic [REP_W-1:0]  rep_mem  [MAX_EFFECTS];
	logic [CNT_W-1:0]  count_reg = '0;
	logic [SEL_W-1:0]  play_effect = '0;
	logic [POS_W-1:0]  play_note = '0;
	logic [REP_W-1:0]  play_round = '0;
	logic [TIME_W-1:0] note_began = '0;
	logic playing_now = 1'b0;
	logic finished_now = 1'b1;
	logic tone_lit = 1'b0;
	logic [FREQ_W-1:0] tone_hz = '0;

	// Stimulus bookkeeping: which notes have been loaded, so that no start or tick
	// ever reaches a note or effect entry that was never written.
	bit written_map [MAX_EFFECTS][NOTES_PER_EFFECT];
	int filled_upto [MAX_EFFECTS];
	logic [LEN_W-1:0] planned_len [MAX_EFFECTS];
	int gen_count = 0;
	logic [TIME_W-1:0] gen_now = '0;

	task automatic flag(input string what);
		if (fail_n < 25)
			$display("ERROR at %0t: %s", $time, what);
		fail_n++;
	endtask

	// Sound a stored note, or fall silent on a zero frequency.
	function automatic void sound_at(input logic [SEL_W-1:0] e, input logic [POS_W-1:0] n);
		logic [FREQ_W-1:0] f;
		f = freq_mem[e][n[NOTE_W-1:0]];
		tone_lit = (f != 0);
		tone_hz = f;
	endfunction

	// Move to the next note once the current one has lasted its duration.
	function automatic void next_note(input logic [TIME_W-1:0] now);
		logic [5:0] span;
		logic [TIME_W-1:0] waited;
		span = len_mem[play_effect];
		if (span > NOTES_PER_EFFECT)
			span = NOTES_PER_EFFECT;
		waited = now - note_began;
		if (waited >= TIME_W'(dur_mem[play_effect][play_note[NOTE_W-1:0]])) begin
			tone_lit = 1'b0;
			tone_hz = '0;
			play_note = play_note + 1'b1;
			note_steps_n++;
			if (play_note >= span) begin
				play_round = play_round + 1'b1;
				if (play_round >= rep_mem[play_effect]) begin
					playing_now = 1'b0;
					finished_now = 1'b1;
					played_out_n++;
				end else begin
					play_note = '0;
				end
			end
			if (playing_now) begin
				sound_at(play_effect, play_note);
				note_began = now;
			end
		end
	endfunction

	// Apply one accepted beat to the predicted player and return its status.
	function automatic status_t predict_status(input item_t b);
		status_t r;
		case (b.op)
			OP_TICK: begin
				ticks_n++;
				if (playing_now)
					next_note(b.time_now);
			end
			OP_START: begin
				starts_n++;
				if (playing_now) begin
					next_note(b.time_now);
				end else if (32'(b.ssel) < 32'(count_reg)) begin
					play_effect = b.ssel;
					play_note = '0;
					play_round = '0;
					note_began = b.time_now;
					playing_now = 1'b1;
					finished_now = 1'b0;
					sound_at(b.ssel, '0);
				end else begin
					refused_n++;
				end
			end
			OP_STOP: begin
				stops_n++;
				tone_lit = 1'b0;
				tone_hz = '0;
				playing_now = 1'b0;
				finished_now = 1'b1;
			end
			default: begin
				loads_n++;
				freq_mem[b.ssel][b.nsel] = b.freq;
				dur_mem[b.ssel][b.nsel] = b.dur;
				len_mem[b.ssel] = b.len;
				rep_mem[b.ssel] = b.reps;
			end
		endcase
		r.tone_on = tone_lit;
		r.tone_freq = tone_lit ? tone_hz : '0;
		r.playing = playing_now;
		r.finished = finished_now;
		return r;
	endfunction

	function automatic item_t beat(input op_t op, input logic [TIME_W-1:0] now,
			input logic [SEL_W-1:0] ss, input logic [SEL_W-1:0] ns,
			input logic [FREQ_W-1:0] f, input logic [DUR_W-1:0] d,
			input logic [LEN_W-1:0] l, input logic [REP_W-1:0] r);
		item_t b;
		b.op = op;
		b.time_now = now;
		b.ssel = ss;
		b.nsel = ns;
		b.freq = f;
		b.dur = d;
		b.len = l;
		b.reps = r;
		return b;
	endfunction

	// Number of leading notes of an effect loaded once note n is written too.
	function automatic int filled_after(input int e, input int n);
		int k;
		k = 0;
		while (k < NOTES_PER_EFFECT && (written_map[e][k] || k == n))
			k++;
		return k;
	endfunction

	function automatic bit playable(input int e);
		int span;
		span = (planned_len[e] == 0) ? 1 :
			(planned_len[e] > NOTES_PER_EFFECT) ? NOTES_PER_EFFECT : int'(planned_len[e]);
		return filled_upto[e] >= span;
	endfunction

	// Mostly a loaded effect that sound_count allows; otherwise any index that
	// is either refused or fully loaded.
	function automatic logic [SEL_W-1:0] pick_start_sel();
		logic [SEL_W-1:0] s;
		logic [SEL_W-1:0] pool[$];
		for (int e = 0; e < MAX_EFFECTS; e++)
			if (e < gen_count && playable(e))
				pool.push_back(SEL_W'(e));
		if (pool.size() > 0 && $urandom_range(99, 0) < 85)
			return pool[$urandom_range(pool.size() - 1, 0)];
		repeat (64) begin
			s = SEL_W'($urandom_range(MAX_EFFECTS - 1, 0));
			if (s >= gen_count || playable(s))
				return s;
		end
		return (pool.size() > 0) ? pool[0] : SEL_W'(MAX_EFFECTS - 1);
	endfunction

	task automatic queue_beat(input item_t b);
		if (b.op == OP_LOAD) begin
			filled_upto[b.ssel] = filled_after(b.ssel, b.nsel);
			written_map[b.ssel][b.nsel] = 1'b1;
			planned_len[b.ssel] = b.len;
		end
		beat_q.push_back(b);
	endtask

	// Time moves on by 0 to 25, now and then jumping anywhere.
	task automatic step_clock();
		if ($urandom_range(99, 0) < 3)
			gen_now = $urandom();
		else
			gen_now = gen_now + $urandom_range(25, 0);
	endtask

	task automatic add_random_beat();
		item_t b;
		int pick;
		int roll;
		int e;
		int n;
		int room;
		b = beat(OP_TICK, $urandom(), SEL_W'($urandom()), SEL_W'($urandom()),
			FREQ_W'($urandom()), DUR_W'($urandom()), LEN_W'($urandom()), REP_W'($urandom()));
		pick = $urandom_range(99, 0);
		if (pick < 58) begin
			step_clock();
			b.time_now = gen_now;
		end else if (pick < 73) begin
			step_clock();
			b.op = OP_START;
			b.time_now = gen_now;
			b.ssel = pick_start_sel();
		end else if (pick < 77) begin
			b.op = OP_STOP;
		end else begin
			b.op = OP_LOAD;
			e = ($urandom_range(99, 0) < 70) ? $urandom_range(5, 0) : $urandom_range(15, 0);
			if (filled_upto[e] < NOTES_PER_EFFECT && $urandom_range(99, 0) < 75)
				n = filled_upto[e];
			else
				n = $urandom_range(NOTES_PER_EFFECT - 1, 0);
			room = filled_after(e, n);
			b.ssel = SEL_W'(e);
			b.nsel = SEL_W'(n);
			roll = $urandom_range(99, 0);
			if (room == 0)
				b.len = LEN_W'($urandom_range(31, 0));
			else if (roll < 10)
				b.len = '0;
			else if (room == NOTES_PER_EFFECT && roll < 25)
				b.len = LEN_W'($urandom_range(31, 17));
			else
				b.len = LEN_W'($urandom_range(room, 1));
			roll = $urandom_range(99, 0);
			b.reps = (roll < 8) ? '0 : (roll < 14) ? REP_W'($urandom()) :
				REP_W'($urandom_range(3, 1));
			b.freq = ($urandom_range(99, 0) < 10) ? '0 : FREQ_W'($urandom());
			roll = $urandom_range(99, 0);
			b.dur = (roll < 8) ? '0 : (roll < 14) ? DUR_W'($urandom()) :
				DUR_W'($urandom_range(40, 1));
		end
		queue_beat(b);
	endtask

	// Write sound_count over the register port, then read it back.
	task automatic program_count(input int value);
		logic [PDATA_W-1:0] read_back;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= SOUND_COUNT_ADDR;
		pwdata <= PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready)
			@(negedge clk);
		@(posedge clk);
		count_reg = CNT_W'(value);
		gen_count = value;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready)
			@(negedge clk);
		read_back = prdata;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (read_back[CNT_W-1:0] !== CNT_W'(value))
			flag($sformatf("sound_count reads %0d after writing %0d",
				read_back[CNT_W-1:0], value));
	endtask

	// Hold the sender back until every outstanding result has come back.
	task automatic wait_quiet();
		do
			@(negedge clk);
		while (beat_q.size() != 0 || in_valid || status_q.size() != 0);
	endtask

	initial begin
		forever #6 clk = ~clk;
	end

	// Cycle limit in case the block hangs.
	always @(posedge clk) begin
		cycle_n <= cycle_n + 1;
		if (cycle_n == RUN_LIMIT) begin
			$display("FAIL tone_sequence_player_core");
			$finish;
		end
	end

	// Input driver: offers queued beats, holding each one steady while stalled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			cur_beat <= '0;
		end else if (!in_valid || !in_stall) begin
			if (beat_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
				cur_beat <= beat_q.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output stall: random, apart from one long hold-off once traffic is flowing.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!held && checked_n >= HOLD_AFTER) begin
			held <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
		end
	end

	// Monitor: predicts each accepted beat and checks each result beat.
	always @(posedge clk) begin
		status_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				status_q.push_back(predict_status(cur_beat));
			if (out_valid && !out_stall) begin
				if (status_q.size() == 0) begin
					flag("result beat with nothing outstanding");
				end else begin
					want = status_q.pop_front();
					checked_n <= checked_n + 1;
					if (tone_on !== want.tone_on)
						flag($sformatf("tone_on is %0b, expected %0b", tone_on, want.tone_on));
					if (tone_freq !== want.tone_freq)
						flag($sformatf("tone_freq is %0d, expected %0d",
							tone_freq, want.tone_freq));
					if (is_playing !== want.playing)
						flag($sformatf("is_playing is %0b, expected %0b",
							is_playing, want.playing));
					if (is_finished !== want.finished)
						flag($sformatf("is_finished is %0b, expected %0b",
							is_finished, want.finished));
				end
			end
		end
	end

	// Sequence: reset, directed beats, then random phases over several settings.
	initial begin
		for (int e = 0; e < MAX_EFFECTS; e++) begin
			filled_upto[e] = 0;
			planned_len[e] = '0;
			len_mem[e] = '0;
			rep_mem[e] = '0;
			for (int n = 0; n < NOTES_PER_EFFECT; n++) begin
				written_map[e][n] = 1'b0;
				freq_mem[e][n] = '0;
				dur_mem[e][n] = '0;
			end
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 31;
		recv_idle_pct = 79;
		program_count(2);

		// Idle tick, a zero-length zero-repeat effect, a refused start, a start
		// while playing, then a full effect with a silent first note across a
		// time wrap, ended by a stop.
		queue_beat(beat(OP_TICK, '0, '0, '0, '0, '0, '0, '0));
		queue_beat(beat(OP_LOAD, '0, 4'd0, 4'd0, 16'd440, 16'd10, 5'd0, 8'd0));
		queue_beat(beat(OP_START, 32'd50, 4'd5, '0, '0, '0, '0, '0));
		queue_beat(beat(OP_START, 32'd100, 4'd0, '0, '0, '0, '0, '0));
		queue_beat(beat(OP_START, 32'd105, 4'd1, '0, '0, '0, '0, '0));
		queue_beat(beat(OP_TICK, 32'd110, '0, '0, '0, '0, '0, '0));
		for (int n = 0; n < NOTES_PER_EFFECT; n++)
			queue_beat(beat(OP_LOAD, '1, 4'd1, SEL_W'(n),
				(n == 0) ? 16'd0 : (n == 15) ? 16'hFFFF : FREQ_W'(200 + 50 * n),
				(n == 0) ? 16'd20 : (n == 15) ? 16'hFFFF : DUR_W'(5 * n),
				(n == 15) ? 5'd31 : LEN_W'(n + 1), (n == 15) ? 8'd255 : 8'd1));
		queue_beat(beat(OP_START, 32'hFFFF_FFF0, 4'd1, '0, '0, '0, '0, '0));
		queue_beat(beat(OP_TICK, 32'd5, '0, '0, '0, '0, '0, '0));
		queue_beat(beat(OP_STOP, '0, '0, '0, '0, '0, '0, '0));
		gen_now = 32'd5;
		wait_quiet();

		for (int p = 0; p < 6; p++) begin
			send_idle_pct = (p < 2) ? 31 : (p < 4) ? 79 : 0;
			recv_idle_pct = (p < 2) ? 79 : (p < 4) ? 31 : 0;
			program_count(phase_counts[p]);
			repeat (BEATS_PER_PHASE)
				add_random_beat();
			wait_quiet();
		end

		repeat (20) @(posedge clk);
		if (status_q.size() != 0)
			flag($sformatf("%0d results never arrived", status_q.size()));
		$display("Covered %0d beats: %0d ticks, %0d starts (%0d refused), %0d stops, %0d loads.",
			ticks_n + starts_n + stops_n + loads_n, ticks_n, starts_n, refused_n,
			stops_n, loads_n);
		$display("Checked %0d results; %0d note changes, %0d effects played to the end.",
			checked_n, note_steps_n, played_out_n);
		if (fail_n == 0)
			$display("PASS tone_sequence_player_core");
		else
			$display("FAIL tone_sequence_player_core");
		$finish;
	end

endmodule

>>> tone_sequence_player_core.f
+incdir+sv
sv/tsp_pkg.sv
sv/tsp_note_store.sv
sv/tsp_effect_store.sv
sv/tsp_player.sv
sv/tone_sequence_player_core.sv
tb/tone_sequence_player_core_tb.sv
